@@ rtl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PrioW = 16;
  localparam int unsigned FillW = 4;
  localparam int unsigned StatW = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [StatW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatW-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [StatW-1:0] STATUS_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic signed [DataW-1:0] data;
    logic signed [PrioW-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'b001,
    OP_INSERT = 3'b010,
    OP_REMOVE = 3'b100
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

@@ rtl/spq_cell.sv @@
// One storage cell of the queue chain: holds an entry and trades with its neighbours.
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  logic                up_le_i,
  input  spq_pkg::entry_t     up_entry_i,
  input  spq_pkg::entry_t     dn_entry_i,
  output logic                le_o,
  output spq_pkg::entry_t     entry_o
);

  spq_pkg::entry_t entry_q, entry_d;

  // empty slots and lower-or-equal priorities make way for the new item
  assign le_o = !valid_i || (entry_q.prio <= ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      spq_pkg::OP_INSERT: begin
        if (le_o) begin
          entry_d = up_le_i ? up_entry_i : ctrl_i.new_entry;
        end
      end
      spq_pkg::OP_REMOVE: begin
        entry_d = dn_entry_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/sorted_priority_queue_core.sv @@
// Sorted priority queue built as a chain of shifting cells.
// Usage:
//   Slave channel s_axis_*: one command item per handshake. tuser is the
//   command (0 insert, 1 remove head); tdata carries data and priority.
//   Master channel m_axis_*: exactly one result item per command. tuser is
//   the status (0 ok, 1 overflow, 2 underflow); tdata carries the removed
//   head (zero otherwise) and the fill count after the command.
// Timing:
//   Every cell compares its priority with the incoming one in parallel and
//   shifts one place, so a command completes in the cycle it is accepted.
//   The result appears in the cycle after acceptance, from the output register.
//   Throughput is one item per cycle while m_axis_tready is high.
// Reset:
//   rst_ni clears the fill count and the output valid; the queue is empty.
// Back-pressure:
//   While a result waits with m_axis_tready low, s_axis_tready drops; when
//   the result is taken a new command is accepted in the same cycle.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // item_data[31:0], item_priority[47:32]
  input  logic        s_axis_tuser,  // cmd[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // out_data[31:0], out_priority[47:32],
                                     // fill_count[51:48], zero[55:52]
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  spq_pkg::entry_t head_q, head_d;
  logic [3:0]      fill_q;
  logic [CntW+3:0] cnt_ext;

  logic                accept, full, empty;
  spq_pkg::cell_ctrl_t ctrl;

  logic            valid [DEPTH];
  logic            le    [DEPTH];
  spq_pkg::entry_t entry [DEPTH];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CntW'(DEPTH));
  assign empty         = (count_q == '0);

  always_comb begin
    ctrl.new_entry.data = s_axis_tdata[31:0];
    ctrl.new_entry.prio = s_axis_tdata[47:32];
    ctrl.op  = spq_pkg::OP_HOLD;
    count_d  = count_q;
    status_d = spq_pkg::STATUS_OK;
    head_d   = '0;
    if (s_axis_tuser == spq_pkg::CMD_INSERT) begin
      if (full) begin
        status_d = spq_pkg::STATUS_OVERFLOW;
      end else if (accept) begin
        ctrl.op = spq_pkg::OP_INSERT;
        count_d = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status_d = spq_pkg::STATUS_UNDERFLOW;
      end else begin
        head_d = entry[0];
        if (accept) begin
          ctrl.op = spq_pkg::OP_REMOVE;
          count_d = count_q - 1'b1;
        end
      end
    end
  end

  assign cnt_ext = {4'b0, count_d};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      assign valid[gi] = (count_q > CntW'(gi));
      spq_cell u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl),
        .valid_i    (valid[gi]),
        .up_le_i    ((gi == 0) ? 1'b0 : le[(gi == 0) ? 0 : gi - 1]),
        .up_entry_i (entry[(gi == 0) ? 0 : gi - 1]),
        .dn_entry_i (entry[(gi == DEPTH - 1) ? gi : gi + 1]),
        .le_o       (le[gi]),
        .entry_o    (entry[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      head_q   <= head_d;
      fill_q   <= cnt_ext[3:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {4'b0, fill_q, head_q.prio, head_q.data};

  // sanity checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  a_overflow_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == spq_pkg::CMD_INSERT && full)
      |=> (count_q == $past(count_q) && m_axis_tuser == spq_pkg::STATUS_OVERFLOW))
    else $error("overflow changed the queue");

  a_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser == spq_pkg::CMD_REMOVE && empty)
      |=> (m_axis_tuser == spq_pkg::STATUS_UNDERFLOW && m_axis_tdata == '0))
    else $error("underflow not reported");

  a_head_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (entry[0].prio >= entry[1].prio))
    else $error("head out of order");

endmodule
